// ===== hw/rtl/sdnv_pkg.sv =====
// Shared types, constants and helper functions for the SDNV encoder.
`timescale 1ns / 1ps

package sdnv_pkg;

   // Field widths and encoding constants.
   localparam int VALUE_W     = 64;
   localparam int BYTE_W      = 8;
   localparam int GROUP_BITS  = 7;
   localparam int MAX_GROUPS  = 10;
   localparam int CNT_W       = 4;
   localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7f;
   localparam int QUEUE_DEPTH = 2;

   // One classified value waiting for the byte emitter.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [CNT_W-1:0]   count;
   } entry_type;

   // Queue occupancy as seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Number of 7-bit groups needed for a value, at least one.
   function automatic logic [CNT_W-1:0] group_count(input logic [VALUE_W-1:0] v);
      logic [CNT_W-1:0] cnt;
      cnt = CNT_W'(1);
      for (int k = 1; k < MAX_GROUPS; k++) begin
         if ((v >> (GROUP_BITS * k)) != '0) begin
            cnt = CNT_W'(k + 1);
         end
      end
      return cnt;
   endfunction

   // Select the 7-bit group at index idx, counted from the least significant end.
   function automatic logic [GROUP_BITS-1:0] group_bits(input logic [VALUE_W-1:0] v,
                                                        input logic [CNT_W-1:0]   idx);
      logic [GROUP_BITS-1:0] g;
      g = '0;
      for (int k = 0; k < MAX_GROUPS; k++) begin
         if (idx == CNT_W'(k)) begin
            g = GROUP_BITS'(v >> (GROUP_BITS * k)) & GROUP_MASK;
         end
      end
      return g;
   endfunction

endpackage

// ===== hw/rtl/sdnv_if.sv =====
// Valid/ready channel interfaces for the SDNV encoder requests and encoded bytes.
`timescale 1ns / 1ps

interface sdnv_req_if import sdnv_pkg::*;;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sdnv_rsp_if import sdnv_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/sdnv_front.sv =====
// Front part: accepts values and tags each with its group count.
`timescale 1ns / 1ps

module sdnv_front import sdnv_pkg::*; (
   input  logic             reset,
   sdnv_req_if.sink         req,
   input  queue_status_type qstat,
   output logic             push,
   output entry_type        push_data
);

   // Take a request whenever the queue has room and reset is not asserted.
   assign req.ready = !qstat.full && !reset;
   assign push      = req.valid && req.ready;

   // Classify the value by the number of groups it needs.
   always_comb begin
      push_data.value = req.value;
      push_data.count = group_count(req.value);
   end

endmodule

// ===== hw/rtl/sdnv_fifo.sv =====
// Short queue that decouples value classification from byte emission.
`timescale 1ns / 1ps

module sdnv_fifo import sdnv_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_data,
   input  logic             pop,
   output entry_type        pop_data,
   output queue_status_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);

   entry_type              store_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;

   assign qstat.full  = (occ_ff == OCC_W'(DEPTH));
   assign qstat.empty = (occ_ff == '0);
   assign pop_data    = store_ff[rd_ptr_ff];

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (pop && !push) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/sdnv_back.sv =====
// Back part: emits the encoded bytes of one value, one byte per cycle unless rsp stalls.
`timescale 1ns / 1ps

module sdnv_back import sdnv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type qstat,
   output logic             pop,
   sdnv_rsp_if.source       rsp
);

   logic                  busy_ff, busy_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic                  slot_free;
   logic                  emit;
   logic                  done;
   logic [GROUP_BITS-1:0] group;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.last     = last_ff;

   // Walk the groups from the most significant one down to group zero.
   always_comb begin
      slot_free    = !rsp_valid_ff || rsp.ready;
      emit         = busy_ff && slot_free;
      done         = emit && (idx_ff == '0);
      pop          = !qstat.empty && (!busy_ff || done);
      group        = group_bits(value_ff, idx_ff);
      busy_in      = busy_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = {(idx_ff != '0), group};
         last_in      = (idx_ff == '0);
         idx_in       = idx_ff - CNT_W'(1);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (pop) begin
         busy_in  = 1'b1;
         value_in = head.value;
         idx_in   = head.count - CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      idx_ff   <= idx_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

endmodule

// ===== hw/rtl/sdnv_encoder.sv =====
// Top level of the SDNV encoder: front classifier, queue and byte emitter.
//
//   Channel  Dir  Payload                    Handshake
//   req      in   value[63:0]                req_chan.valid / req_chan.ready
//   rsp      out  out_byte[7:0], last        rsp_chan.valid / rsp_chan.ready
//
// A value needing N groups (1 to 10) yields N bytes, one per cycle while rsp is
// not stalled, so the emitter loop sets the throughput once the queue is full.
// Up to QUEUE_DEPTH_P (default QUEUE_DEPTH) classified values wait between the front and the emitter.
// Reset is synchronous and clears the queue pointers and the emitter state.
// A stalled rsp holds its byte; the front keeps taking requests while the
// queue has room.
`timescale 1ns / 1ps

module sdnv_encoder import sdnv_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   sdnv_req_if.sink    req_chan,
   sdnv_rsp_if.source  rsp_chan
);

   queue_status_type qstat;
   logic             push;
   logic             pop;
   entry_type        push_data;
   entry_type        head;

   sdnv_front u_front (
      .reset     (reset),
      .req       (req_chan),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   sdnv_fifo #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (head),
      .qstat     (qstat)
   );

   sdnv_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ===== hw/rtl/sdnv_encoder_checker.sv =====
// Port-level checks for the SDNV encoder, bound to the top level.
`timescale 1ns / 1ps

module sdnv_encoder_checker import sdnv_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_last
);

   logic [CNT_W-1:0] run_ff, run_in;

   // Count bytes taken since the last final byte.
   always_comb begin
      run_in = run_ff;
      if (rsp_valid && rsp_ready) begin
         run_in = rsp_last ? '0 : run_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   // A stalled byte stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp byte changed while stalled");

   // The continuation mark is set exactly on bytes that are not final.
   a_cont_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_byte[BYTE_W-1] == !rsp_last))
      else $error("continuation mark disagrees with last flag");

   // No encoding is longer than ten bytes.
   a_max_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (run_ff == CNT_W'(MAX_GROUPS - 1)) |-> rsp_last)
      else $error("encoding longer than ten bytes");

   // A multi-byte encoding never opens with an empty group.
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (run_ff == '0) && rsp_out_byte[BYTE_W-1]
         |-> (rsp_out_byte[GROUP_BITS-1:0] != '0))
      else $error("leading group of a multi-byte encoding is zero");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind sdnv_encoder sdnv_encoder_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last     (rsp_chan.last)
);
